>>> rtl/bpa_pkg.sv
// Shared constants, types and helper functions of the buddy page allocator.
// Depends on nothing; used by bpa_ctrl, bpa_datapath and the top level.
package bpa_pkg;

  localparam int unsigned MIN_PAGE_SHIFT = 8;
  localparam int unsigned MAX_ORDER      = 3;
  localparam int unsigned TOP_BLOCKS     = 16;

  localparam int unsigned NUM_ORD   = MAX_ORDER + 1;
  localparam int unsigned OW        = (NUM_ORD > 2) ? $clog2(NUM_ORD) : 1;
  localparam int unsigned IXW       = $clog2(TOP_BLOCKS) + MAX_ORDER;
  localparam int unsigned LW        = IXW + 1;
  localparam int unsigned TOTAL     = TOP_BLOCKS * ((2 << MAX_ORDER) - 1);
  localparam int unsigned AW        = $clog2(TOTAL);
  localparam int unsigned TOP_SHIFT = MIN_PAGE_SHIFT + MAX_ORDER;
  localparam int unsigned POOL_W    = TOP_SHIFT + $clog2(TOP_BLOCKS);

  localparam logic [LW-1:0] NIL = {LW{1'b1}};

  // field widths of the stream items
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned GORD_W   = 2;
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 40;
  localparam int unsigned PADDR_W  = 3;

  localparam logic REG_POOL_BASE = 1'b0;  // word select, paddr bit 2
  localparam logic OP_ALLOC      = 1'b0;

  typedef enum logic [STAT_W-1:0] {
    ST_OK, ST_NO_MEM, ST_BAD_SIZE, ST_BAD_FREE
  } status_e;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_CLR, CMD_LOAD, CMD_A_PICK, CMD_RD_LNK, CMD_UNL1, CMD_UNL2,
    CMD_S1, CMD_S2, CMD_S3, CMD_A_FIN, CMD_ERR_SIZE, CMD_ERR_OOM, CMD_ERR_FREE,
    CMD_F_INIT, CMD_F_RD, CMD_F_NXT, CMD_F_CHILD_RD, CMD_F_CLR, CMD_BUD_RD,
    CMD_F_UP, CMD_P1, CMD_P2, CMD_F_FIN
  } cmd_e;

  typedef struct packed {
    logic is_free;
    logic bad_size;
    logic no_block;
    logic bad_range;
    logic bit_rd;
    logic o_eq_want;
    logic o_eq_hi;
    logic o_zero;
    logic o_max;
    logic clr_done;
    logic out_busy;
  } dp_stat_t;

  // first flat index of the bits and links of one order
  function automatic logic [AW-1:0] base_of(input logic [OW-1:0] o);
    logic [AW-1:0] b;
    b = '0;
    for (int p = 0; p < int'(MAX_ORDER); p++) begin
      if (p < int'(o)) b = b + AW'(TOP_BLOCKS << (MAX_ORDER - p));
    end
    return b;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [OW-1:0] o,
                                            input logic [IXW-1:0] x);
    return AW'(base_of(o) + AW'(x));
  endfunction

endpackage

>>> rtl/bpa_datapath.sv
// Datapath of the buddy page allocator: bit and link memories, list heads,
// working registers, pool_base register and the result register.
// Depends on bpa_pkg; driven by bpa_ctrl through a command code.
module bpa_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpa_pkg::cmd_e                cmd_i,
  output bpa_pkg::dp_stat_t            stat_o,
  input  logic [bpa_pkg::S_DATA_W-1:0] s_tdata_i,
  input  logic                         s_tuser_i,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [bpa_pkg::M_DATA_W-1:0] m_tdata_o,
  output logic [bpa_pkg::STAT_W-1:0]   m_tuser_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [bpa_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [31:0]                  pwdata_i,
  output logic [31:0]                  prdata_o
);

  localparam int unsigned IXW = bpa_pkg::IXW;
  localparam int unsigned OW  = bpa_pkg::OW;
  localparam int unsigned LW  = bpa_pkg::LW;
  localparam int unsigned AW  = bpa_pkg::AW;

  logic                       bit_mem [bpa_pkg::TOTAL];
  logic [LW-1:0]              nxt_mem [bpa_pkg::TOTAL];
  logic [LW-1:0]              prv_mem [bpa_pkg::TOTAL];

  logic                       bit_we, nxt_we, prv_we, bit_wd;
  logic [AW-1:0]              bit_wa, nxt_wa, prv_wa, bit_ra, lnk_ra;
  logic [LW-1:0]              nxt_wd, prv_wd;
  logic                       bit_rd_q;
  logic [LW-1:0]              nxt_rd_q, prv_rd_q;

  logic [LW-1:0]              heads_q [bpa_pkg::NUM_ORD];
  logic [LW-1:0]              heads_d [bpa_pkg::NUM_ORD];
  logic [AW-1:0]              clr_q;
  logic                       is_free_q;
  logic [bpa_pkg::SIZE_W-1:0] size_q;
  logic [31:0]                faddr_q, base_q;
  logic [OW-1:0]              o_q, o_d, want_q, found_q, found_d;
  logic [IXW-1:0]             x_q, x_d;

  logic                       mvalid_q;
  logic [1:0]                 st_q;
  logic [31:0]                baddr_q;
  logic [OW-1:0]              gord_q;
  logic                       res_we;
  logic [1:0]                 res_st;
  logic [31:0]                res_addr;
  logic [OW-1:0]              res_ord;

  // decode of the latched item
  logic [bpa_pkg::SIZE_W-1:0] s_pages;
  logic                       bad_size;
  logic [OW-1:0]              want, sel_ord, hi, om1, op1;
  logic                       no_block;
  logic [31:0]                off, aoff;
  logic                       bad_range;
  logic [IXW-1:0]             page, page_o, tgt, x2;
  logic [AW-1:0]              top_base, tix;
  logic                       topb;

  always_comb begin
    bad_size = (size_q == '0) ||
               ({16'b0, size_q} > (32'd1 << bpa_pkg::TOP_SHIFT));
    s_pages  = (size_q - 16'd1) >> bpa_pkg::MIN_PAGE_SHIFT;
    want     = '0;
    for (int k = 0; k < int'(bpa_pkg::MAX_ORDER); k++) begin
      if ((s_pages >> k) != '0) want = OW'(k + 1);
    end
    no_block = 1'b1;
    sel_ord  = '0;
    for (int k = int'(bpa_pkg::MAX_ORDER); k >= 0; k--) begin
      if ((k >= int'(want)) && (heads_q[k] != bpa_pkg::NIL)) begin
        no_block = 1'b0;
        sel_ord  = OW'(k);
      end
    end
    off       = faddr_q - base_q;
    bad_range = (off[31:bpa_pkg::POOL_W] != '0) ||
                (off[bpa_pkg::MIN_PAGE_SHIFT-1:0] != '0);
    page      = off[bpa_pkg::POOL_W-1:bpa_pkg::MIN_PAGE_SHIFT];
    hi        = OW'(bpa_pkg::MAX_ORDER);
    for (int k = int'(bpa_pkg::MAX_ORDER) - 1; k >= 0; k--) begin
      if (page[k]) hi = OW'(k);
    end
    page_o   = page >> o_q;
    tgt      = is_free_q ? (x_q ^ IXW'(1)) : x_q;
    x2       = {x_q[IXW-2:0], 1'b0};
    om1      = o_q - OW'(1);
    op1      = o_q + OW'(1);
    aoff     = 32'(x_q) << (bpa_pkg::MIN_PAGE_SHIFT + 32'(want_q));
    top_base = bpa_pkg::base_of(OW'(bpa_pkg::MAX_ORDER));
    topb     = clr_q >= top_base;
    tix      = clr_q - top_base;
  end

  always_comb begin
    bit_we = 1'b0; bit_wa = '0; bit_wd = 1'b0; bit_ra = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = bpa_pkg::NIL;
    prv_we = 1'b0; prv_wa = '0; prv_wd = bpa_pkg::NIL;
    lnk_ra = '0;
    heads_d = heads_q;
    o_d = o_q; x_d = x_q; found_d = found_q;
    res_we = 1'b0; res_st = bpa_pkg::ST_OK; res_addr = '0; res_ord = '0;
    case (cmd_i)
      bpa_pkg::CMD_CLR: begin
        bit_we = 1'b1; nxt_we = 1'b1; prv_we = 1'b1;
        bit_wa = clr_q; nxt_wa = clr_q; prv_wa = clr_q;
        bit_wd = (clr_q == AW'(bpa_pkg::TOTAL - 1));
        if (topb && (tix != '0) && (tix != AW'(bpa_pkg::TOP_BLOCKS - 1)))
          nxt_wd = LW'(tix - AW'(1));
        if (topb && (tix < AW'(bpa_pkg::TOP_BLOCKS - 2)))
          prv_wd = LW'(tix + AW'(1));
      end
      bpa_pkg::CMD_A_PICK: begin
        o_d = sel_ord;
        x_d = heads_q[sel_ord][IXW-1:0];
      end
      bpa_pkg::CMD_RD_LNK: lnk_ra = bpa_pkg::addr_of(o_q, tgt);
      bpa_pkg::CMD_UNL1: begin
        if (prv_rd_q != bpa_pkg::NIL) begin
          nxt_we = 1'b1;
          nxt_wa = bpa_pkg::addr_of(o_q, prv_rd_q[IXW-1:0]);
          nxt_wd = nxt_rd_q;
        end else if (heads_q[o_q] == LW'(tgt)) begin
          heads_d[o_q] = nxt_rd_q;
        end
        if (nxt_rd_q != bpa_pkg::NIL) begin
          prv_we = 1'b1;
          prv_wa = bpa_pkg::addr_of(o_q, nxt_rd_q[IXW-1:0]);
          prv_wd = prv_rd_q;
        end
      end
      bpa_pkg::CMD_UNL2: begin
        nxt_we = 1'b1; prv_we = 1'b1;
        nxt_wa = bpa_pkg::addr_of(o_q, tgt);
        prv_wa = bpa_pkg::addr_of(o_q, tgt);
      end
      bpa_pkg::CMD_S1: begin
        bit_we = 1'b1; bit_wd = 1'b1;
        bit_wa = bpa_pkg::addr_of(o_q, x_q);
      end
      bpa_pkg::CMD_S2: begin
        bit_we = 1'b1; nxt_we = 1'b1; prv_we = 1'b1;
        bit_wa = bpa_pkg::addr_of(om1, x2);
        nxt_wa = bpa_pkg::addr_of(om1, x2);
        prv_wa = bpa_pkg::addr_of(om1, x2);
        nxt_wd = heads_q[om1];
      end
      bpa_pkg::CMD_S3: begin
        if (heads_q[om1] != bpa_pkg::NIL) begin
          prv_we = 1'b1;
          prv_wa = bpa_pkg::addr_of(om1, heads_q[om1][IXW-1:0]);
          prv_wd = LW'(x2);
        end
        heads_d[om1] = LW'(x2);
        x_d = x2 | IXW'(1);
        o_d = om1;
      end
      bpa_pkg::CMD_A_FIN: begin
        bit_we = 1'b1; bit_wd = 1'b1;
        bit_wa = bpa_pkg::addr_of(want_q, x_q);
        res_we = 1'b1; res_addr = base_q + aoff; res_ord = want_q;
      end
      bpa_pkg::CMD_ERR_SIZE: begin
        res_we = 1'b1; res_st = bpa_pkg::ST_BAD_SIZE;
      end
      bpa_pkg::CMD_ERR_OOM: begin
        res_we = 1'b1; res_st = bpa_pkg::ST_NO_MEM;
      end
      bpa_pkg::CMD_ERR_FREE: begin
        res_we = 1'b1; res_st = bpa_pkg::ST_BAD_FREE;
      end
      bpa_pkg::CMD_F_INIT: o_d = '0;
      bpa_pkg::CMD_F_RD:   bit_ra = bpa_pkg::addr_of(o_q, page_o);
      bpa_pkg::CMD_F_NXT:  o_d = op1;
      bpa_pkg::CMD_F_CHILD_RD:
        bit_ra = bpa_pkg::addr_of(om1, {page_o[IXW-2:0], 1'b1});
      bpa_pkg::CMD_F_CLR: begin
        bit_we = 1'b1; bit_wa = bpa_pkg::addr_of(o_q, page_o);
        x_d = page_o; found_d = o_q;
      end
      bpa_pkg::CMD_BUD_RD: bit_ra = bpa_pkg::addr_of(o_q, x_q ^ IXW'(1));
      bpa_pkg::CMD_F_UP: begin
        bit_we = 1'b1; bit_wa = bpa_pkg::addr_of(op1, x_q >> 1);
        x_d = x_q >> 1; o_d = op1;
      end
      bpa_pkg::CMD_P1: begin
        nxt_we = 1'b1; prv_we = 1'b1;
        nxt_wa = bpa_pkg::addr_of(o_q, x_q);
        prv_wa = bpa_pkg::addr_of(o_q, x_q);
        nxt_wd = heads_q[o_q];
      end
      bpa_pkg::CMD_P2: begin
        if (heads_q[o_q] != bpa_pkg::NIL) begin
          prv_we = 1'b1;
          prv_wa = bpa_pkg::addr_of(o_q, heads_q[o_q][IXW-1:0]);
          prv_wd = LW'(x_q);
        end
        heads_d[o_q] = LW'(x_q);
      end
      bpa_pkg::CMD_F_FIN: begin
        res_we = 1'b1; res_ord = found_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bit_we) bit_mem[bit_wa] <= bit_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    bit_rd_q <= bit_mem[bit_ra];
    nxt_rd_q <= nxt_mem[lnk_ra];
    prv_rd_q <= prv_mem[lnk_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(bpa_pkg::NUM_ORD); k++) heads_q[k] <= bpa_pkg::NIL;
      heads_q[bpa_pkg::MAX_ORDER] <= LW'(bpa_pkg::TOP_BLOCKS - 2);
      clr_q    <= '0;
      mvalid_q <= 1'b0;
      base_q   <= '0;
    end else begin
      heads_q <= heads_d;
      if (cmd_i == bpa_pkg::CMD_CLR) clr_q <= clr_q + AW'(1);
      if (res_we) mvalid_q <= 1'b1;
      else if (m_tready_i) mvalid_q <= 1'b0;
      if (psel_i && penable_i && pwrite_i && (paddr_i[2] == bpa_pkg::REG_POOL_BASE))
        base_q <= pwdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    o_q <= o_d; x_q <= x_d; found_q <= found_d;
    if (cmd_i == bpa_pkg::CMD_LOAD) begin
      is_free_q <= (s_tuser_i != bpa_pkg::OP_ALLOC);
      size_q    <= s_tdata_i[bpa_pkg::SIZE_W-1:0];
      faddr_q   <= s_tdata_i[bpa_pkg::S_DATA_W-1:bpa_pkg::SIZE_W];
    end
    if (cmd_i == bpa_pkg::CMD_LOAD) want_q <= '0;
    else if (cmd_i == bpa_pkg::CMD_A_PICK || want_q != want) want_q <= want;
    if (res_we) begin
      st_q <= res_st; baddr_q <= res_addr; gord_q <= res_ord;
    end
  end

  assign prdata_o = (paddr_i[2] == bpa_pkg::REG_POOL_BASE) ? base_q : 32'd0;

  assign m_tvalid_o = mvalid_q;
  assign m_tuser_o  = st_q;
  assign m_tdata_o  = {6'b0, bpa_pkg::GORD_W'(gord_q), baddr_q};

  assign stat_o.is_free   = is_free_q;
  assign stat_o.bad_size  = bad_size;
  assign stat_o.no_block  = no_block;
  assign stat_o.bad_range = bad_range;
  assign stat_o.bit_rd    = bit_rd_q;
  assign stat_o.o_eq_want = (o_q == want_q);
  assign stat_o.o_eq_hi   = (o_q == hi);
  assign stat_o.o_zero    = (o_q == '0);
  assign stat_o.o_max     = (o_q == OW'(bpa_pkg::MAX_ORDER));
  assign stat_o.clr_done  = (clr_q == AW'(bpa_pkg::TOTAL - 1));
  assign stat_o.out_busy  = mvalid_q && !m_tready_i;

endmodule

>>> rtl/bpa_ctrl.sv
// Sequencer of the buddy page allocator: walks alloc, split, free and
// merge steps and issues one datapath command per cycle. Depends on bpa_pkg.
module bpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  bpa_pkg::dp_stat_t stat_i,
  output bpa_pkg::cmd_e     cmd_o
);

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_DISP = 5'd2,
    S_A_PICK = 5'd3, S_RD_LNK = 5'd4, S_UNL1 = 5'd5, S_UNL2 = 5'd6,
    S_A_LOOP = 5'd7, S_S1 = 5'd8, S_S2 = 5'd9, S_S3 = 5'd10, S_A_FIN = 5'd11,
    S_ERR_SIZE = 5'd12, S_ERR_OOM = 5'd13, S_ERR_FREE = 5'd14, S_F_RD = 5'd15,
    S_F_CK = 5'd16, S_F_CHILD_CK = 5'd17, S_F_CLR = 5'd18, S_M_CK = 5'd19,
    S_BUD_CK = 5'd20, S_F_UP = 5'd21, S_P1 = 5'd22, S_P2 = 5'd23,
    S_F_FIN = 5'd24;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = bpa_pkg::CMD_NOP;
    case (state_q)
      S_CLR: begin
        cmd_o = bpa_pkg::CMD_CLR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o = bpa_pkg::CMD_LOAD; state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_free) begin
          if (stat_i.bad_range) state_d = S_ERR_FREE;
          else begin
            cmd_o = bpa_pkg::CMD_F_INIT; state_d = S_F_RD;
          end
        end else if (stat_i.bad_size) state_d = S_ERR_SIZE;
        else if (stat_i.no_block) state_d = S_ERR_OOM;
        else state_d = S_A_PICK;
      end
      S_A_PICK: begin cmd_o = bpa_pkg::CMD_A_PICK; state_d = S_RD_LNK; end
      S_RD_LNK: begin cmd_o = bpa_pkg::CMD_RD_LNK; state_d = S_UNL1; end
      S_UNL1:   begin cmd_o = bpa_pkg::CMD_UNL1;   state_d = S_UNL2; end
      S_UNL2: begin
        cmd_o   = bpa_pkg::CMD_UNL2;
        state_d = stat_i.is_free ? S_F_UP : S_A_LOOP;
      end
      S_A_LOOP: state_d = stat_i.o_eq_want ? S_A_FIN : S_S1;
      S_S1: begin cmd_o = bpa_pkg::CMD_S1; state_d = S_S2; end
      S_S2: begin cmd_o = bpa_pkg::CMD_S2; state_d = S_S3; end
      S_S3: begin cmd_o = bpa_pkg::CMD_S3; state_d = S_A_LOOP; end
      S_A_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o = bpa_pkg::CMD_A_FIN; state_d = S_IDLE;
        end
      end
      S_ERR_SIZE: begin
        if (!stat_i.out_busy) begin
          cmd_o = bpa_pkg::CMD_ERR_SIZE; state_d = S_IDLE;
        end
      end
      S_ERR_OOM: begin
        if (!stat_i.out_busy) begin
          cmd_o = bpa_pkg::CMD_ERR_OOM; state_d = S_IDLE;
        end
      end
      S_ERR_FREE: begin
        if (!stat_i.out_busy) begin
          cmd_o = bpa_pkg::CMD_ERR_FREE; state_d = S_IDLE;
        end
      end
      S_F_RD: begin cmd_o = bpa_pkg::CMD_F_RD; state_d = S_F_CK; end
      // lowest order with its bit set at this page
      S_F_CK: begin
        if (stat_i.bit_rd) begin
          if (stat_i.o_zero) state_d = S_F_CLR;
          else begin
            cmd_o = bpa_pkg::CMD_F_CHILD_RD; state_d = S_F_CHILD_CK;
          end
        end else if (stat_i.o_eq_hi) state_d = S_ERR_FREE;
        else begin
          cmd_o = bpa_pkg::CMD_F_NXT; state_d = S_F_RD;
        end
      end
      // upper child still set means the block is split, not used
      S_F_CHILD_CK: state_d = stat_i.bit_rd ? S_ERR_FREE : S_F_CLR;
      S_F_CLR: begin cmd_o = bpa_pkg::CMD_F_CLR; state_d = S_M_CK; end
      S_M_CK: begin
        if (stat_i.o_max) state_d = S_P1;
        else begin
          cmd_o = bpa_pkg::CMD_BUD_RD; state_d = S_BUD_CK;
        end
      end
      S_BUD_CK: state_d = stat_i.bit_rd ? S_P1 : S_RD_LNK;
      S_F_UP: begin cmd_o = bpa_pkg::CMD_F_UP; state_d = S_M_CK; end
      S_P1:   begin cmd_o = bpa_pkg::CMD_P1;   state_d = S_P2; end
      S_P2:   begin cmd_o = bpa_pkg::CMD_P2;   state_d = S_F_FIN; end
      S_F_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o = bpa_pkg::CMD_F_FIN; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else state_q <= state_d;
  end

  assign s_tready_o = (state_q == S_IDLE);

endmodule

>>> rtl/buddy_page_allocator.sv
// Top level of the buddy page allocator: sequencer plus datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
//
// Buddy allocator over 16 top blocks of 2 KiB, orders 0..3 (256 B pages).
// After reset a clearing pass initializes the bit and link
// memories; no item is taken meanwhile, APB writes are. One item is worked
// at a time: an alloc unlinks a free block and splits it down to the wanted
// order, and a free searches the orders at the page and merges with free
// buddies, the sequencer walking through the bit and link memories.
// The result sits in an output register, so the next item may be taken
// while it waits.
module buddy_page_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [bpa_pkg::S_DATA_W-1:0] s_tdata_i,  // size_bytes[15:0], free_address[47:16]
  input  logic                         s_tuser_i,  // opcode
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [bpa_pkg::M_DATA_W-1:0] m_tdata_o,  // block_address[31:0], granted_order[33:32]
  output logic [bpa_pkg::STAT_W-1:0]   m_tuser_o,  // status
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [bpa_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [31:0]                  pwdata_i,
  output logic [31:0]                  prdata_o,
  output logic                         pready_o
);

  bpa_pkg::cmd_e     cmd;
  bpa_pkg::dp_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .psel_i     (psel_i),
    .penable_i  (penable_i),
    .pwrite_i   (pwrite_i),
    .paddr_i    (paddr_i),
    .pwdata_i   (pwdata_i),
    .prdata_o   (prdata_o)
  );

  assign pready_o = 1'b1;

endmodule

>>> test/buddy_page_allocator_checker.sv
// Result checker for the buddy page allocator: snoops the APB and both streams,
// keeps its own copy of the allocator state and compares every result.
// Depends on bpa_pkg.
module buddy_page_allocator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,  // size_bytes[15:0], free_address[47:16]
  input  logic        s_tuser_i,  // opcode
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,  // block_address[31:0], granted_order[33:32]
  input  logic [1:0]  m_tuser_i,  // status
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int unsigned NENT = 240;
  localparam logic [15:0] EMPTY = 16'hFFFF;

  typedef struct {
    bpa_pkg::status_e status;
    logic [31:0]      addr;
    logic [1:0]       order;
  } grant_t;

  logic        in_use [NENT];
  logic [15:0] link_nx [NENT];
  logic [15:0] link_pv [NENT];
  logic [15:0] head [4];
  logic [31:0] base_addr;
  grant_t      grants_q[$];

  function automatic int unsigned n_at(int unsigned o);
    return 16 << (3 - o);
  endfunction

  function automatic int unsigned first_at(int unsigned o);
    int unsigned b;
    b = 0;
    for (int unsigned p = 0; p < o; p++) b += n_at(p);
    return b;
  endfunction

  function automatic logic get_bit(int unsigned o, int unsigned ix);
    if (o > 3 || ix >= n_at(o)) return 1'b0;
    return in_use[first_at(o) + ix];
  endfunction

  function automatic void put_bit(int unsigned o, int unsigned ix, logic v);
    if (o > 3 || ix >= n_at(o)) return;
    in_use[first_at(o) + ix] = v;
  endfunction

  function automatic void push_free(int unsigned o, int unsigned ix);
    int unsigned b;
    logic [15:0] h;
    b = first_at(o);
    h = head[o];
    if (ix >= n_at(o)) return;
    link_nx[b + ix] = h;
    link_pv[b + ix] = EMPTY;
    if (h != EMPTY && h < n_at(o)) link_pv[b + h] = 16'(ix);
    head[o] = 16'(ix);
  endfunction

  function automatic void drop_free(int unsigned o, int unsigned ix);
    int unsigned b;
    logic [15:0] nx, pv;
    b = first_at(o);
    if (ix >= n_at(o)) return;
    nx = link_nx[b + ix];
    pv = link_pv[b + ix];
    if (pv != EMPTY && pv < n_at(o)) link_nx[b + pv] = nx;
    else if (head[o] == 16'(ix)) head[o] = nx;
    if (nx != EMPTY && nx < n_at(o)) link_pv[b + nx] = pv;
    link_nx[b + ix] = EMPTY;
    link_pv[b + ix] = EMPTY;
  endfunction

  function automatic logic has_free(int unsigned o);
    return head[o] != EMPTY && head[o] < n_at(o);
  endfunction

  function automatic void clear_pool();
    for (int i = 0; i < NENT; i++) begin
      in_use[i] = 1'b0;
      link_nx[i] = EMPTY;
      link_pv[i] = EMPTY;
    end
    for (int o = 0; o < 4; o++) head[o] = EMPTY;
    for (int unsigned i = 0; i < 15; i++) push_free(3, i);
    put_bit(3, 15, 1'b1);
    base_addr = '0;
  endfunction

  function automatic grant_t allocate(logic [15:0] size);
    grant_t g;
    int unsigned want, o, s, ix;
    g = '{bpa_pkg::ST_OK, 32'd0, 2'd0};
    if (size == 0 || size > 16'd2048) begin
      g.status = bpa_pkg::ST_BAD_SIZE;
      return g;
    end
    want = 0;
    s = (32'(size) - 1) >> 8;
    while (want < 3 && s != 0) begin
      want++;
      s >>= 1;
    end
    o = want;
    while (o <= 3 && !has_free(o)) o++;
    if (o > 3) begin
      g.status = bpa_pkg::ST_NO_MEM;
      return g;
    end
    ix = head[o];
    drop_free(o, ix);
    // split down: lower half goes on the list, upper half is kept
    while (o > want) begin
      put_bit(o, ix, 1'b1);
      o--;
      ix <<= 1;
      put_bit(o, ix, 1'b0);
      push_free(o, ix);
      ix += 1;
    end
    put_bit(want, ix, 1'b1);
    g.addr = base_addr + (ix << (8 + want));
    g.order = 2'(want);
    return g;
  endfunction

  function automatic grant_t release_block(logic [31:0] addr);
    grant_t g;
    logic [31:0] off;
    int unsigned page, cur, hi, o, found;
    logic any;
    g = '{bpa_pkg::ST_BAD_FREE, 32'd0, 2'd0};
    off = addr - base_addr;
    if (off >= 32'd32768 || off[7:0] != 0) return g;
    page = off >> 8;
    hi = 0;
    while (hi < 3 && ((page >> hi) & 1) == 0) hi++;
    found = 0;
    any = 1'b0;
    for (o = 0; o <= hi; o++) begin
      if (!any && get_bit(o, page >> o)) begin
        found = o;
        any = 1'b1;
      end
    end
    if (!any) return g;
    if (found > 0 && get_bit(found - 1, ((page >> found) << 1) + 1)) return g;
    cur = page >> found;
    put_bit(found, cur, 1'b0);
    o = found;
    while (o < 3 && !get_bit(o, cur ^ 1)) begin
      drop_free(o, cur ^ 1);
      cur >>= 1;
      o++;
      put_bit(o, cur, 1'b0);
    end
    push_free(o, cur);
    g.status = bpa_pkg::ST_OK;
    g.order = 2'(found);
    return g;
  endfunction

  initial begin
    errors_o = 0;
    clear_pool();
  end

  assign pending_o = grants_q.size();

  // Sample at the falling edge: these values hold through the next rising edge.
  always @(negedge clk_i) begin
    grant_t want_g;
    if (!rst_ni) begin
      clear_pool();
      grants_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[2] == bpa_pkg::REG_POOL_BASE)
        base_addr = pwdata_i;
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == bpa_pkg::OP_ALLOC)
          grants_q.push_back(allocate(s_tdata_i[15:0]));
        else grants_q.push_back(release_block(s_tdata_i[47:16]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (grants_q.size() == 0) begin
          $error("unexpected result: status %0d addr %h", m_tuser_i, m_tdata_i[31:0]);
          errors_o++;
        end else begin
          want_g = grants_q.pop_front();
          if (m_tuser_i != want_g.status) begin
            $error("status: expected %0d, got %0d", want_g.status, m_tuser_i);
            errors_o++;
          end
          if (m_tdata_i[31:0] != want_g.addr) begin
            $error("block_address: expected %h, got %h", want_g.addr, m_tdata_i[31:0]);
            errors_o++;
          end
          if (m_tdata_i[33:32] != want_g.order) begin
            $error("granted_order: expected %0d, got %0d", want_g.order, m_tdata_i[33:32]);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

>>> test/buddy_page_allocator_test.sv
// Top of the buddy page allocator testbench: clock, reset, APB writes and
// request traffic. Depends on bpa_pkg, buddy_page_allocator and the checker.
module buddy_page_allocator_test;

  localparam logic OP_RELEASE = ~bpa_pkg::OP_ALLOC;
  localparam logic [2:0] POOL_BASE_ADDR = {bpa_pkg::REG_POOL_BASE, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;

  logic        calm = 1'b0;      // no idling on either side
  logic        stall_req = 1'b0; // ask the receiver for one long hold-off
  int          stall_left = 0;
  logic [31:0] pool_base = '0;
  logic [31:0] live_q[$];        // offsets of blocks believed allocated
  logic        ops_q[$];
  int          n_alloc_ok = 0, n_free_ok = 0, n_fail = 0;

  always #2 clk_i = ~clk_i;

  buddy_page_allocator u_dut (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata), .m_tuser_o(m_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  buddy_page_allocator_checker u_check (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata), .m_tuser_i(m_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    #4000000;
    $display("** buddy_page_allocator: FAILED **");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  always @(posedge clk_i) begin
    if (stall_req && stall_left == 0) begin
      stall_req <= 1'b0;
      stall_left <= 400;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 36);
    end
  end

  // track live blocks from the results so frees can target them
  always @(negedge clk_i) begin
    logic op;
    if (rst_ni && m_tvalid && m_tready && ops_q.size() > 0) begin
      op = ops_q.pop_front();
      if (m_tuser != bpa_pkg::ST_OK) n_fail++;
      else if (op == bpa_pkg::OP_ALLOC) begin
        n_alloc_ok++;
        live_q.push_back(m_tdata[31:0] - pool_base);
      end else n_free_ok++;
    end
  end

  task automatic send(logic op, logic [15:0] size, logic [31:0] addr);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {addr, size};
    do @(negedge clk_i); while (!s_tready);
    @(posedge clk_i);
    ops_q.push_back(op);
    if (!calm && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_base(logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= POOL_BASE_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pool_base = value;
  endtask

  task automatic free_live();
    int k;
    k = $urandom_range(live_q.size() - 1);
    send(OP_RELEASE, 16'($urandom), pool_base + live_q[k]);
    live_q.delete(k);
  endtask

  task automatic random_item();
    int pick;
    logic [31:0] off;
    pick = $urandom_range(99);
    if (live_q.size() > 0 && pick < 42) free_live();
    else if (pick < 82) begin
      if ($urandom_range(9) == 0) send(bpa_pkg::OP_ALLOC, 16'($urandom), $urandom);
      else send(bpa_pkg::OP_ALLOC, 16'($urandom_range(1, 2048)), $urandom);
    end else begin
      case ($urandom_range(3))
        0: off = {17'd0, 4'($urandom), 3'($urandom), 8'd0};    // maybe free or split
        1: off = {17'd0, 15'($urandom)} | 32'd1 << $urandom_range(7);
        2: off = 32'd32768 + $urandom_range(32'h7FFF_0000);
        default: off = $urandom;
      endcase
      send(OP_RELEASE, 16'($urandom), pool_base + off);
    end
  endtask

  initial begin
    logic [15:0] sizes[9] = '{1, 256, 257, 512, 1024, 2048, 0, 2049, 65535};
    logic [31:0] gone;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_base(32'h0000_0000);

    // directed: every order, bad sizes, bad frees, reserved block, full-size allocations
    foreach (sizes[i]) send(bpa_pkg::OP_ALLOC, sizes[i], 32'hFFFF_FFFF);
    drain();
    gone = live_q[0];
    free_live();
    send(OP_RELEASE, 16'hFFFF, pool_base + gone);      // first block: a double free only if free_live chose it
    send(OP_RELEASE, 16'h0, pool_base + 32'h80);       // not page aligned
    send(OP_RELEASE, 16'h0, pool_base + 32'h8000);     // past the pool
    send(OP_RELEASE, 16'h0, pool_base + 32'h7800);     // reserved top block
    drain();
    repeat (13) send(bpa_pkg::OP_ALLOC, 16'd2048, 32'h0);  // full-size allocations from the free top blocks
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_base(32'hFFFF_F800);
        1: set_base({$urandom} & 32'hFFFF_F800);
        2: set_base(32'h7FFF_8000);
        default: set_base(32'h0000_0000);
      endcase
      calm = (ph == 2);
      for (int n = 0; n < 130; n++) begin
        if (ph == 1 && n == 20) stall_req = 1'b1;
        if (n == 70) drain();
        random_item();
      end
      drain();
    end

    $display("covered %0d allocations and %0d frees granted, %0d refused, over 5 pool bases",
             n_alloc_ok, n_free_ok, n_fail);
    if (errors == 0) $display("** buddy_page_allocator: PASSED **");
    else $display("** buddy_page_allocator: FAILED **");
    $finish;
  end

endmodule
